// File: sv/i6ts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i6ts_pkg: shared types and constants for the IPv6 text shortener
// Group and character widths, the zero-run summary type and the hex-digit
// to ASCII mapping.
// ----------------------------------------------------------------------------
package i6ts_pkg;

   localparam int GROUP_COUNT = 8;
   localparam int GROUP_W     = 16;
   localparam int NIBBLE_W    = 4;
   localparam int NIBBLES     = GROUP_W / NIBBLE_W;
   localparam int ADDR_W      = GROUP_COUNT * GROUP_W;
   localparam int GROUP_IDX_W = $clog2(GROUP_COUNT);
   localparam int RUN_LEN_W   = $clog2(GROUP_COUNT + 1);
   localparam int DIGIT_IDX_W = $clog2(NIBBLES);
   localparam int CHAR_W      = 8;

   localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;

   localparam logic COMPRESS_RESET = 1'b1;

   // Longest zero-group run found by the scanner
   typedef struct packed {
      logic                   done;
      logic [GROUP_IDX_W-1:0] start;
      logic [RUN_LEN_W-1:0]   len;
   } run_info_type;

   // Map one nibble to its lower-case ASCII hex digit
   function automatic logic [CHAR_W-1:0] hex_char(input logic [NIBBLE_W-1:0] nib);
      logic [CHAR_W-1:0] wide;
      begin
         wide = {{(CHAR_W-NIBBLE_W){1'b0}}, nib};
         if (nib < 4'd10) begin
            hex_char = CHAR_ZERO + wide;
         end else begin
            hex_char = CHAR_LOWER_A + wide - 8'd10;
         end
      end
   endfunction

endpackage

// File: sv/i6ts_run_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i6ts_run_finder: serial zero-run scanner
// Shifts the per-group zero flags through one bit per cycle and keeps the
// longest run of zero groups; the earliest run wins a tie.
// ----------------------------------------------------------------------------
module i6ts_run_finder (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [i6ts_pkg::GROUP_COUNT-1:0]       zero_mask,
   output i6ts_pkg::run_info_type                 run_info
);
   import i6ts_pkg::*;

   logic                   active_ff,    active_in;
   logic                   done_ff,      done_in;
   logic [GROUP_IDX_W-1:0] idx_ff,       idx_in;
   logic [GROUP_COUNT-1:0] mask_ff,      mask_in;
   logic [RUN_LEN_W-1:0]   cur_len_ff,   cur_len_in;
   logic [GROUP_IDX_W-1:0] cur_start_ff, cur_start_in;
   logic [RUN_LEN_W-1:0]   best_len_ff,  best_len_in;
   logic [GROUP_IDX_W-1:0] best_start_ff, best_start_in;

   logic [RUN_LEN_W-1:0]   step_len;
   logic [GROUP_IDX_W-1:0] step_start;

   // Step one group flag per cycle
   always_comb begin
      active_in     = active_ff;
      done_in       = 1'b0;
      idx_in        = idx_ff;
      mask_in       = mask_ff;
      cur_len_in    = cur_len_ff;
      cur_start_in  = cur_start_ff;
      best_len_in   = best_len_ff;
      best_start_in = best_start_ff;
      step_len      = cur_len_ff + 1'b1;
      step_start    = (cur_len_ff == '0) ? idx_ff : cur_start_ff;

      if (start) begin
         active_in     = 1'b1;
         idx_in        = '0;
         mask_in       = zero_mask;
         cur_len_in    = '0;
         cur_start_in  = '0;
         best_len_in   = '0;
         best_start_in = '0;
      end else if (active_ff) begin
         mask_in = mask_ff >> 1;
         if (mask_ff[0]) begin
            cur_len_in   = step_len;
            cur_start_in = step_start;
            // take over only on a strictly longer run
            if (step_len > best_len_ff) begin
               best_len_in   = step_len;
               best_start_in = step_start;
            end
         end else begin
            cur_len_in = '0;
         end
         idx_in = idx_ff + 1'b1;
         if (idx_ff == GROUP_IDX_W'(GROUP_COUNT - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      idx_ff        <= idx_in;
      mask_ff       <= mask_in;
      cur_len_ff    <= cur_len_in;
      cur_start_ff  <= cur_start_in;
      best_len_ff   <= best_len_in;
      best_start_ff <= best_start_in;
   end

   assign run_info.done  = done_ff;
   assign run_info.start = best_start_ff;
   assign run_info.len   = best_len_ff;

endmodule

// File: sv/i6ts_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i6ts_serializer: nibble-serial text generator
// Shifts the held address out one hex nibble per cycle unless a printed
// digit waits on the output stall, drops leading zeros, inserts separators
// and the double colon, and drives the output register.
module i6ts_serializer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load,
   input  logic [i6ts_pkg::ADDR_W-1:0]          address,
   input  logic                                 compress_enable,
   input  i6ts_pkg::run_info_type               run_info,
   output logic                                 busy,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [i6ts_pkg::CHAR_W-1:0]          rsp_out_char,
   output logic                                 rsp_last_char,
   output logic                                 rsp_was_compressed
);
   import i6ts_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_GROUP,
      S_SEP,
      S_DIGIT,
      S_DC1,
      S_DC2
   } state_type;

   localparam logic [RUN_LEN_W-1:0]   RUN_END_MAX = RUN_LEN_W'(GROUP_COUNT);
   localparam logic [GROUP_IDX_W-1:0] GROUP_LAST  = GROUP_IDX_W'(GROUP_COUNT - 1);
   localparam logic [DIGIT_IDX_W-1:0] DIGIT_LAST  = DIGIT_IDX_W'(NIBBLES - 1);

   state_type               state_ff,   state_in;
   logic [ADDR_W-1:0]       shift_ff,   shift_in;
   logic [GROUP_IDX_W-1:0]  grp_ff,     grp_in;
   logic [DIGIT_IDX_W-1:0]  dig_ff,     dig_in;
   logic                    started_ff, started_in;
   logic                    comp_ff,    comp_in;
   logic [GROUP_IDX_W-1:0]  rs_ff,      rs_in;
   logic [RUN_LEN_W-1:0]    len_ff,     len_in;
   logic                    valid_ff,   valid_in;
   logic [CHAR_W-1:0]       char_ff,    char_in;
   logic                    last_ff,    last_in;
   logic                    wasc_ff,    wasc_in;

   logic                    advance;
   logic [RUN_LEN_W-1:0]    run_end;
   logic [RUN_LEN_W-1:0]    grp_wide;
   logic                    in_run;
   logic [NIBBLE_W-1:0]     nib;
   logic                    show_nib;
   logic                    run_ok;

   assign advance  = !valid_ff || !rsp_stall;
   assign run_end  = {1'b0, rs_ff} + len_ff;
   assign grp_wide = {1'b0, grp_ff};
   assign in_run   = comp_ff && (grp_wide >= {1'b0, rs_ff}) && (grp_wide < run_end);
   assign nib      = shift_ff[ADDR_W-1 -: NIBBLE_W];
   assign show_nib = (nib != '0) || started_ff || (dig_ff == DIGIT_LAST);
   assign run_ok   = compress_enable && (run_info.len >= RUN_LEN_W'(2));

   always_comb begin
      state_in   = state_ff;
      shift_in   = shift_ff;
      grp_in     = grp_ff;
      dig_in     = dig_ff;
      started_in = started_ff;
      comp_in    = comp_ff;
      rs_in      = rs_ff;
      len_in     = len_ff;
      valid_in   = valid_ff;
      char_in    = char_ff;
      last_in    = last_ff;
      wasc_in    = wasc_ff;

      // drop the output once transferred
      if (advance) begin
         valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (load) begin
               shift_in = address;
               state_in = S_SCAN;
            end
         end

         // wait for the zero-run scan, latch the chosen run
         S_SCAN: begin
            if (run_info.done) begin
               comp_in  = run_ok;
               rs_in    = run_ok ? run_info.start : '0;
               len_in   = run_ok ? run_info.len : '0;
               grp_in   = '0;
               state_in = S_GROUP;
            end
         end

         // decide what this group produces
         S_GROUP: begin
            dig_in     = '0;
            started_in = 1'b0;
            if (in_run) begin
               if (grp_ff == rs_ff) begin
                  state_in = S_DC1;
               end else begin
                  // skip a compressed group
                  shift_in = {shift_ff[ADDR_W-GROUP_W-1:0], {GROUP_W{1'b0}}};
                  grp_in   = grp_ff + 1'b1;
                  if (grp_ff == GROUP_LAST) begin
                     state_in = S_IDLE;
                  end
               end
            end else if ((grp_ff != '0) && !(comp_ff && (grp_wide == run_end))) begin
               state_in = S_SEP;
            end else begin
               state_in = S_DIGIT;
            end
         end

         S_SEP: begin
            if (advance) begin
               valid_in = 1'b1;
               char_in  = CHAR_COLON;
               last_in  = 1'b0;
               wasc_in  = comp_ff;
               state_in = S_DIGIT;
            end
         end

         // one nibble per cycle unless a printed digit is stalled, leading zeros dropped
         S_DIGIT: begin
            if (advance || !show_nib) begin
               if (show_nib) begin
                  valid_in = 1'b1;
                  char_in  = hex_char(nib);
                  last_in  = (dig_ff == DIGIT_LAST) && (grp_ff == GROUP_LAST);
                  wasc_in  = comp_ff;
               end
               shift_in   = {shift_ff[ADDR_W-NIBBLE_W-1:0], {NIBBLE_W{1'b0}}};
               dig_in     = dig_ff + 1'b1;
               started_in = started_ff || (nib != '0);
               if (dig_ff == DIGIT_LAST) begin
                  grp_in   = grp_ff + 1'b1;
                  state_in = (grp_ff == GROUP_LAST) ? S_IDLE : S_GROUP;
               end
            end
         end

         S_DC1: begin
            if (advance) begin
               valid_in = 1'b1;
               char_in  = CHAR_COLON;
               last_in  = 1'b0;
               wasc_in  = comp_ff;
               state_in = S_DC2;
            end
         end

         S_DC2: begin
            if (advance) begin
               valid_in = 1'b1;
               char_in  = CHAR_COLON;
               last_in  = (run_end == RUN_END_MAX);
               wasc_in  = comp_ff;
               if (run_end == RUN_END_MAX) begin
                  state_in = S_IDLE;
               end else begin
                  shift_in = {shift_ff[ADDR_W-GROUP_W-1:0], {GROUP_W{1'b0}}};
                  grp_in   = grp_ff + 1'b1;
                  state_in = S_GROUP;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         grp_ff   <= '0;
         dig_ff   <= '0;
         comp_ff  <= 1'b0;
         rs_ff    <= '0;
         len_ff   <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         grp_ff   <= grp_in;
         dig_ff   <= dig_in;
         comp_ff  <= comp_in;
         rs_ff    <= rs_in;
         len_ff   <= len_in;
      end
      shift_ff   <= shift_in;
      started_ff <= started_in;
      char_ff    <= char_in;
      last_ff    <= last_in;
      wasc_ff    <= wasc_in;
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = valid_ff;
   assign rsp_out_char       = char_ff;
   assign rsp_last_char      = last_ff;
   assign rsp_was_compressed = wasc_ff;

endmodule

// File: sv/ipv6_text_shortener_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv6_text_shortener_unit: IPv6 address to shortened text
// Takes eight 16-bit groups and streams the compressed lower-case text form,
// one ASCII character per transfer, with a last-character flag.
// ----------------------------------------------------------------------------
// One address is in work at a time; req_stall stays high until its last
// character has been loaded into the output register. After the transfer
// the zero-group flags are scanned one group per cycle and the longest run
// is handed over. The text is then generated nibble by nibble: each group
// passes a decision state, a separator colon where one is due, and its four
// nibbles in turn, each printed or dropped (a printed character waits while
// the output stalls); a compressed group other than the first of its run
// passes its decision state only, and the first of the run emits the double
// colon. The output register lets the next address be taken while the final
// character still waits.
// ----------------------------------------------------------------------------
module ipv6_text_shortener_unit (
   input  logic                              clock,
   input  logic                              reset,
   // address input
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [i6ts_pkg::GROUP_W-1:0]      req_group_0,
   input  logic [i6ts_pkg::GROUP_W-1:0]      req_group_1,
   input  logic [i6ts_pkg::GROUP_W-1:0]      req_group_2,
   input  logic [i6ts_pkg::GROUP_W-1:0]      req_group_3,
   input  logic [i6ts_pkg::GROUP_W-1:0]      req_group_4,
   input  logic [i6ts_pkg::GROUP_W-1:0]      req_group_5,
   input  logic [i6ts_pkg::GROUP_W-1:0]      req_group_6,
   input  logic [i6ts_pkg::GROUP_W-1:0]      req_group_7,
   // character output
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [i6ts_pkg::CHAR_W-1:0]       rsp_out_char,
   output logic                              rsp_last_char,
   output logic                              rsp_was_compressed,
   // configuration write
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic                              csr_compress_enable
);
   import i6ts_pkg::*;

   logic                   compress_ff, compress_in;
   logic                   busy;
   logic                   req_take;
   logic [GROUP_COUNT-1:0] zero_mask;
   logic [ADDR_W-1:0]      address;
   run_info_type           run_info;

   // write the configuration register
   assign csr_ready   = 1'b1;
   assign compress_in = (csr_valid && csr_ready) ? csr_compress_enable : compress_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         compress_ff <= COMPRESS_RESET;
      end else begin
         compress_ff <= compress_in;
      end
   end

   // accept an address only while idle
   assign req_stall = busy;
   assign req_take  = req_valid && !req_stall;

   assign address = {req_group_0, req_group_1, req_group_2, req_group_3,
                     req_group_4, req_group_5, req_group_6, req_group_7};

   // flag all-zero groups, group 0 in bit 0
   assign zero_mask = {req_group_7 == '0, req_group_6 == '0, req_group_5 == '0,
                       req_group_4 == '0, req_group_3 == '0, req_group_2 == '0,
                       req_group_1 == '0, req_group_0 == '0};

   i6ts_run_finder u_run_finder (
      .clock     (clock),
      .reset     (reset),
      .start     (req_take),
      .zero_mask (zero_mask),
      .run_info  (run_info)
   );

   i6ts_serializer u_serializer (
      .clock              (clock),
      .reset              (reset),
      .load               (req_take),
      .address            (address),
      .compress_enable    (compress_ff),
      .run_info           (run_info),
      .busy               (busy),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_char       (rsp_out_char),
      .rsp_last_char      (rsp_last_char),
      .rsp_was_compressed (rsp_was_compressed)
   );

   // busy right after an address transfer
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> req_stall)
      else $error("unit not busy after address transfer");

   // scan result arrives only while an address is in work
   assert property (@(posedge clock) disable iff (reset)
      run_info.done |-> busy)
      else $error("zero-run result while idle");

   // chosen run stays inside the address
   assert property (@(posedge clock) disable iff (reset)
      run_info.done |-> (({1'b0, run_info.start} + run_info.len) <= RUN_LEN_W'(GROUP_COUNT)))
      else $error("zero run exceeds the group count");

endmodule
